// ----- hdl/ipv4arp_pkg.sv -----
// shared types and constants for the ipv4 receive classifier with arp cache
// no dependencies
`timescale 1ns / 1ps

package ipv4arp_pkg;

    localparam logic [15:0] TYPE_ARP  = 16'h0806;
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP = 8'd17;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [15:0] DNS_PORT  = 16'd53;
    localparam int          ETH_LEN   = 14;
    localparam int          IPV4_MIN  = 14 + 20;
    localparam int          ARP_LEN   = 42;
    localparam logic [3:0]  IHL_MASK  = 4'hF;
    localparam int          LEN_W     = 7;

    localparam logic [1:0] REG_OWN_IP  = 2'd0;
    localparam logic [1:0] REG_MASK    = 2'd1;
    localparam logic [1:0] REG_GATEWAY = 2'd2;

    typedef enum logic [3:0] {
        KIND_DROP      = 4'd0,
        KIND_ARP_LEARN = 4'd1,
        KIND_ARP_SKIP  = 4'd2,
        KIND_UDP       = 4'd3,
        KIND_UDP_DNS   = 4'd4,
        KIND_TCP       = 4'd5,
        KIND_IGNORED   = 4'd6,
        KIND_HIT       = 4'd7,
        KIND_MISS      = 4'd8
    } kind_t;

    // one request from the parser to the classifier; src carries the query on lookups
    typedef struct packed {
        logic              lookup;
        logic [LEN_W-1:0]  len;
        logic [15:0]       ether_kind;
        logic              arp_ok;
        logic [47:0]       sender_hw;
        logic [7:0]        vhl;
        logic [15:0]       total_length;
        logic [7:0]        proto;
        logic [31:0]       src;
        logic [31:0]       dst;
        logic [31:0]       ports;
    } req_t;

    typedef struct packed {
        logic [31:0] route_ip;
        logic [47:0] hw_address;
        logic [15:0] payload_length;
        logic [6:0]  payload_offset;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [31:0] dest_address;
        logic [31:0] source_address;
    } res_t;

endpackage

// ----- hdl/ipv4arp_front.sv -----
// byte parser: captures header fields and emits one request per frame or lookup
// depends on ipv4arp_pkg
`timescale 1ns / 1ps

module ipv4arp_front #(
    parameter int MAX_FRAME = 2048
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                op,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic [31:0]         query_ip,
    output logic                push,
    output ipv4arp_pkg::req_t   push_req
);
    import ipv4arp_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0]   ek_reg, ek_next;
    logic          arp_ok_reg, arp_ok_next;
    logic [47:0]   shw_reg, shw_next;
    logic [7:0]    vhl_reg, vhl_next;
    logic [15:0]   tl_reg, tl_next;
    logic [7:0]    proto_reg, proto_next;
    logic [31:0]   src_reg, src_next;
    logic [31:0]   dst_reg, dst_next;
    logic [31:0]   ports_reg, ports_next;

    logic [5:0]    ihl;
    logic [CW-1:0] pos;
    logic          is_arp, is_ip;

    assign pos    = cnt_reg;
    assign ihl    = {vhl_reg[3:0] & IHL_MASK, 2'b00};
    assign is_arp = (ek_reg == TYPE_ARP) && (pos >= CW'(ETH_LEN));
    assign is_ip  = (ek_reg == TYPE_IPV4) && (pos >= CW'(ETH_LEN));

    always_comb
    begin
        logic [7:0] fmt;
        logic [CW-1:0] cnt_cap;
        cnt_cap     = cnt_reg;
        fmt         = 8'h00;
        ek_next     = ek_reg;
        arp_ok_next = arp_ok_reg;
        shw_next    = shw_reg;
        vhl_next    = vhl_reg;
        tl_next     = tl_reg;
        proto_next  = proto_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        ports_next  = ports_reg;
        case (pos)
            CW'(15): fmt = 8'h01;
            CW'(16): fmt = 8'h08;
            CW'(17): fmt = 8'h00;
            CW'(18): fmt = 8'h06;
            CW'(19): fmt = 8'h04;
            default: fmt = 8'h00;
        endcase
        if (accept && !op && (cnt_reg < CW'(MAX_FRAME)))
        begin
            cnt_cap = cnt_reg + CW'(1);
            if (pos == CW'(12) || pos == CW'(13))
                ek_next = {ek_reg[7:0], data_byte};
            if (is_arp)
            begin
                if (pos == CW'(14))
                    arp_ok_next = (data_byte == 8'h00);
                else if (pos <= CW'(19))
                    arp_ok_next = arp_ok_reg && (data_byte == fmt);
                if (pos >= CW'(22) && pos <= CW'(27))
                    shw_next = {shw_reg[39:0], data_byte};
                if (pos >= CW'(28) && pos <= CW'(31))
                    src_next = {src_reg[23:0], data_byte};
            end
            if (is_ip)
            begin
                if (pos == CW'(14))
                    vhl_next = data_byte;
                if (pos == CW'(16) || pos == CW'(17))
                    tl_next = {tl_reg[7:0], data_byte};
                if (pos == CW'(23))
                    proto_next = data_byte;
                if (pos >= CW'(26) && pos <= CW'(29))
                    src_next = {src_reg[23:0], data_byte};
                if (pos >= CW'(30) && pos <= CW'(33))
                    dst_next = {dst_reg[23:0], data_byte};
                if (pos > CW'(ETH_LEN) && ihl >= 6'd20
                    && pos >= CW'(ETH_LEN) + CW'(ihl)
                    && pos < CW'(ETH_LEN + 4) + CW'(ihl))
                    ports_next = {ports_reg[23:0], data_byte};
            end
        end

        push_req.lookup       = op;
        push_req.len          = (cnt_cap >= CW'(2**LEN_W - 1)) ? {LEN_W{1'b1}}
                                                               : cnt_cap[LEN_W-1:0];
        push_req.ether_kind   = ek_next;
        push_req.arp_ok       = arp_ok_next;
        push_req.sender_hw    = shw_next;
        push_req.vhl          = vhl_next;
        push_req.total_length = tl_next;
        push_req.proto        = proto_next;
        push_req.src          = op ? query_ip : src_next;
        push_req.dst          = dst_next;
        push_req.ports        = ports_next;

        push     = accept && (op || last_byte);
        cnt_next = cnt_cap;
        // frame done: start the next one from a clean slate
        if (accept && !op && last_byte)
        begin
            cnt_next    = '0;
            ek_next     = '0;
            arp_ok_next = 1'b0;
            shw_next    = '0;
            vhl_next    = '0;
            tl_next     = '0;
            proto_next  = '0;
            src_next    = '0;
            dst_next    = '0;
            ports_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            ek_reg     <= '0;
            arp_ok_reg <= 1'b0;
            shw_reg    <= '0;
            vhl_reg    <= '0;
            tl_reg     <= '0;
            proto_reg  <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
            ports_reg  <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            ek_reg     <= ek_next;
            arp_ok_reg <= arp_ok_next;
            shw_reg    <= shw_next;
            vhl_reg    <= vhl_next;
            tl_reg     <= tl_next;
            proto_reg  <= proto_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            ports_reg  <= ports_next;
        end
    end

endmodule

// ----- hdl/ipv4arp_queue.sv -----
// four-entry request queue between parser and classifier
// depends on ipv4arp_pkg
`timescale 1ns / 1ps

module ipv4arp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ipv4arp_pkg::req_t push_req,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output ipv4arp_pkg::req_t pop_req
);
    import ipv4arp_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    req_t          mem [DEPTH];
    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full      = (cnt_reg == (AW+1)'(DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_req   = mem[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + AW'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + AW'(1) : rd_reg;
        cnt_next = cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- hdl/ipv4arp_back.sv -----
// classifier and arp cache: executes queued requests into the output register
// depends on ipv4arp_pkg
`timescale 1ns / 1ps

module ipv4arp_back #(
    parameter int CACHE_ENTRIES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              req_valid,
    input  ipv4arp_pkg::req_t req,
    output logic              req_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output ipv4arp_pkg::kind_t out_kind,
    output ipv4arp_pkg::res_t out_res
);
    import ipv4arp_pkg::*;

    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    logic [31:0] own_ip_reg, mask_reg, gw_reg;
    logic [31:0] cache_addr_reg [CACHE_ENTRIES];
    logic [47:0] cache_hw_mem   [CACHE_ENTRIES];

    logic        valid_reg, valid_next;
    kind_t       kind_reg, kind_c;
    res_t        res_reg, res_c;

    logic [31:0] key, hop;
    logic        found, empty_found, learn;
    logic [IW-1:0] match_idx, empty_idx, wr_idx;
    logic [5:0]  ihl;
    logic [15:0] pl;

    assign req_pop   = req_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_res   = res_reg;

    assign hop = (((req.src ^ own_ip_reg) & mask_reg) != '0) ? gw_reg : req.src;
    assign key = req.lookup ? hop : req.src;
    assign ihl = {req.vhl[3:0] & IHL_MASK, 2'b00};
    assign pl  = req.total_length - 16'(ihl);

    // parallel search; the first matching and first empty entries win
    always_comb
    begin
        found       = 1'b0;
        empty_found = 1'b0;
        match_idx   = '0;
        empty_idx   = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--)
        begin
            if (cache_addr_reg[i] == key)
            begin
                found     = 1'b1;
                match_idx = IW'(i);
            end
            if (cache_addr_reg[i] == '0)
            begin
                empty_found = 1'b1;
                empty_idx   = IW'(i);
            end
        end
        wr_idx = found ? match_idx : (empty_found ? empty_idx : '0);
    end

    always_comb
    begin
        kind_c = KIND_DROP;
        res_c  = '0;
        learn  = 1'b0;
        if (req.lookup)
        begin
            res_c.route_ip = hop;
            if (found && hop != '0)
            begin
                kind_c           = KIND_HIT;
                res_c.hw_address = cache_hw_mem[match_idx];
            end
            else
                kind_c = KIND_MISS;
        end
        else if (req.len < LEN_W'(ETH_LEN))
            kind_c = KIND_DROP;
        else if (req.ether_kind == TYPE_ARP)
        begin
            if (req.len >= LEN_W'(ARP_LEN) && req.arp_ok)
            begin
                res_c.source_address = req.src;
                res_c.hw_address     = req.sender_hw;
                if (req.src != '0)
                begin
                    kind_c = KIND_ARP_LEARN;
                    learn  = 1'b1;
                end
                else
                    kind_c = KIND_ARP_SKIP;
            end
        end
        else if (req.ether_kind == TYPE_IPV4)
        begin
            if (req.len >= LEN_W'(IPV4_MIN) && req.vhl[7:4] == 4'd4 && ihl >= 6'd20
                && req.len >= LEN_W'(ETH_LEN + 4) + LEN_W'(ihl)
                && req.total_length >= 16'(ihl))
            begin
                if (req.proto == PROTO_UDP)
                begin
                    if (pl >= 16'd8)
                    begin
                        kind_c = (req.ports[31:16] == DNS_PORT) ? KIND_UDP_DNS : KIND_UDP;
                        res_c.payload_offset = 7'(ETH_LEN + 8) + 7'(ihl);
                        res_c.payload_length = pl - 16'd8;
                    end
                end
                else if (req.proto == PROTO_TCP)
                begin
                    if (pl >= 16'd20)
                    begin
                        kind_c               = KIND_TCP;
                        res_c.payload_offset = 7'(ETH_LEN) + 7'(ihl);
                        res_c.payload_length = pl;
                    end
                end
                else
                    kind_c = KIND_IGNORED;
                if (kind_c != KIND_DROP)
                begin
                    res_c.source_address = req.src;
                    res_c.dest_address   = req.dst;
                end
                if (kind_c != KIND_DROP && kind_c != KIND_IGNORED)
                begin
                    res_c.source_port = req.ports[31:16];
                    res_c.dest_port   = req.ports[15:0];
                end
            end
        end
        else
            kind_c = KIND_IGNORED;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (req_pop)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_pop)
        begin
            kind_reg <= kind_c;
            res_reg  <= res_c;
            if (learn)
                cache_hw_mem[wr_idx] <= req.sender_hw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            own_ip_reg <= '0;
            mask_reg   <= '0;
            gw_reg     <= '0;
            for (int i = 0; i < CACHE_ENTRIES; i++)
                cache_addr_reg[i] <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OWN_IP:  own_ip_reg <= cfg_data;
                    REG_MASK:    mask_reg   <= cfg_data;
                    REG_GATEWAY: gw_reg     <= cfg_data;
                    default:     ;
                endcase
            end
            if (req_pop && learn)
                cache_addr_reg[wr_idx] <= req.src;
        end
    end

    a_learn_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (req_pop && learn) |-> (req.src != '0))
        else $error("arp learn with zero sender address");

    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == KIND_HIT) |-> (res_reg.route_ip != '0))
        else $error("hit reported for zero route address");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(kind_reg) && $stable(res_reg)))
        else $error("stalled result changed");

endmodule

// ----- hdl/eth_ipv4_rx_classifier_arp_cache.sv -----
// top level of the ethernet ipv4 receive classifier with arp cache
// depends on ipv4arp_pkg, ipv4arp_front, ipv4arp_queue, ipv4arp_back
`timescale 1ns / 1ps

// usage
//   s_axis: one request per clock while tready is high. tuser is op (0 frame
//   byte, 1 address lookup), tlast ends a frame, tdata holds byte and query.
//   m_axis: one result per completed frame and per lookup; tuser is the kind code.
//   cfg: write own_ip (0), subnet_mask (1) and gateway_ip (2) while idle.
//   throughput: one request per clock sustained while m_axis_tready stays high;
//   bytes not ending a frame are absorbed by the parser and produce nothing.
//   path: a taken last byte or lookup goes into the four-entry queue, then the
//   classifier and cache write it into the output register when it leaves
//   the queue, which may wait behind older entries or a stalled receiver.
//   reset clears the parser, the queue, the output valid flag (not the result
//   data), the config registers and all cache addresses (cache empty).
//   when the receiver stalls, the output holds and the queue fills; s_axis_tready
//   drops once the queue is full, and the parser keeps its partial frame.
module eth_ipv4_rx_classifier_arp_cache #(
    parameter int CACHE_ENTRIES = 8,
    parameter int MAX_FRAME     = 2048
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // data_byte[7:0], query_ip[39:8]
    input  logic         s_axis_tlast,
    input  logic         s_axis_tuser,   // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // source_address, dest_address, source_port, dest_port, payload_offset,
    // payload_length, hw_address, route_ip, one zero pad bit
    output logic [199:0] m_axis_tdata,
    output logic [3:0]   m_axis_tuser,   // kind
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import ipv4arp_pkg::*;

    logic  accept, push, full, pop, pop_valid;
    req_t  push_req, pop_req;
    kind_t kind;
    res_t  res;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    ipv4arp_front #(.MAX_FRAME(MAX_FRAME)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (s_axis_tuser),
        .data_byte (s_axis_tdata[7:0]),
        .last_byte (s_axis_tlast),
        .query_ip  (s_axis_tdata[39:8]),
        .push      (push),
        .push_req  (push_req)
    );

    ipv4arp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_req  (push_req),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_req   (pop_req)
    );

    ipv4arp_back #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (pop_valid),
        .req       (pop_req),
        .req_pop   (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (kind),
        .out_res   (res)
    );

    assign m_axis_tuser = kind;
    assign m_axis_tdata = {1'b0, res};

endmodule
